// ----- src/sts_pkg.sv -----
// shared types and constants for the sorted table search engine
`timescale 1ns / 1ps

package sts_pkg;

  localparam int TableDepthDef = 32;
  localparam int ValueWidthDef = 32;

  localparam int OpWidth     = 2;
  localparam int IndexWidth  = 5;
  localparam int FieldWidth  = 32;
  localparam int LengthWidth = 6;
  localparam int PosWidth    = 5;

  typedef enum logic [OpWidth-1:0] {
    OpWrite      = 2'd0,
    OpBinary     = 2'd1,
    OpSequential = 2'd2
  } sts_op_e;

  typedef struct packed {
    logic                found;
    logic [PosWidth-1:0] position;
  } sts_result_t;

endpackage

// ----- src/sts_if.sv -----
// request and result channel interfaces
`timescale 1ns / 1ps

interface sts_req_if import sts_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic [OpWidth-1:0]           operation;
  logic [IndexWidth-1:0]        entry_index;
  logic signed [FieldWidth-1:0] entry_value;
  logic signed [FieldWidth-1:0] search_key;

  modport source (
    output valid, operation, entry_index, entry_value, search_key,
    input  ready
  );
  modport sink (
    input  valid, operation, entry_index, entry_value, search_key,
    output ready
  );
endinterface

interface sts_rsp_if import sts_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                found;
  logic [PosWidth-1:0] position;

  modport source (
    output valid, found, position,
    input  ready
  );
  modport sink (
    input  valid, found, position,
    output ready
  );
endinterface

// ----- src/sts_ram.sv -----
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps

module sts_ram import sts_pkg::*; #(
  parameter int Width = ValueWidthDef,
  parameter int Depth = TableDepthDef
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/sts_ctrl.sv -----
// search sequencer: length register, binary and linear probe control, result register
`timescale 1ns / 1ps

module sts_ctrl import sts_pkg::*; #(
  parameter int TableDepth = TableDepthDef,
  parameter int ValueWidth = ValueWidthDef,
  localparam int Aw = $clog2(TableDepth)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // request channel
  input  logic                         req_valid_i,
  output logic                         req_ready_o,
  input  logic [OpWidth-1:0]           req_operation_i,
  input  logic [IndexWidth-1:0]        req_entry_index_i,
  input  logic signed [FieldWidth-1:0] req_entry_value_i,
  input  logic signed [FieldWidth-1:0] req_search_key_i,
  // length register
  input  logic                         cfg_we_i,
  input  logic [LengthWidth-1:0]       cfg_wdata_i,
  // result channel
  output logic                         rsp_valid_o,
  input  logic                         rsp_ready_i,
  output sts_result_t                  rsp_result_o,
  // table memories, two copies written together
  output logic                         ram_we_o,
  output logic [Aw-1:0]                ram_waddr_o,
  output logic [ValueWidth-1:0]        ram_wdata_o,
  output logic [Aw-1:0]                ram_raddr0_o,
  output logic [Aw-1:0]                ram_raddr1_o,
  input  logic [ValueWidth-1:0]        ram_rdata0_i,
  input  logic [ValueWidth-1:0]        ram_rdata1_i
);

  localparam int Uw = Aw + 1;
  localparam int Iw = Aw + 2;
  localparam int Cw = (Uw > LengthWidth) ? Uw : LengthWidth;

  localparam logic [2:0] SIdle  = 3'd0;
  localparam logic [2:0] SBound = 3'd1;
  localparam logic [2:0] SMid   = 3'd2;
  localparam logic [2:0] SScan  = 3'd3;
  localparam logic [2:0] SDone  = 3'd4;

  logic [2:0]             state_q, state_d;
  logic [LengthWidth-1:0] length_q;
  logic signed [Iw-1:0]   lo_q, lo_d, hi_q, hi_d;
  logic [Aw-1:0]          mid_q, mid_d;
  logic [Cw-1:0]          idx_q, idx_d;
  logic signed [ValueWidth-1:0] key_q, key_d;
  sts_result_t            res_q, res_d;
  logic                   out_valid_q, out_valid_d;
  sts_result_t            out_res_q, out_res_d;

  logic [Cw-1:0]          used_len;
  logic [Uw-1:0]          used_u;
  logic signed [Iw-1:0]   mid_sum;
  logic signed [Iw-1:0]   mid_ext;
  logic [Cw-1:0]          idx_next;
  logic signed [ValueWidth-1:0] key_in;
  logic signed [ValueWidth-1:0] rd0, rd1;

  // input words are cut or widened to the stored width
  if (ValueWidth <= FieldWidth) begin : g_narrow
    assign key_in      = req_search_key_i[ValueWidth-1:0];
    assign ram_wdata_o = req_entry_value_i[ValueWidth-1:0];
  end else begin : g_wide
    assign key_in      = {{(ValueWidth-FieldWidth){1'b0}}, req_search_key_i};
    assign ram_wdata_o = {{(ValueWidth-FieldWidth){1'b0}}, req_entry_value_i};
  end

  assign rd0 = ram_rdata0_i;
  assign rd1 = ram_rdata1_i;

  // length beyond the table depth is clamped
  assign used_len = (int'(length_q) > TableDepth) ? Cw'(TableDepth) : Cw'(length_q);
  assign used_u   = Uw'(used_len);
  assign mid_sum  = (lo_q + hi_q) >>> 1;
  assign mid_ext  = {2'b00, mid_q};
  assign idx_next = idx_q + Cw'(1);

  assign ram_waddr_o = Aw'(req_entry_index_i);
  assign req_ready_o = (state_q == SIdle);

  always_comb begin
    state_d      = state_q;
    lo_d         = lo_q;
    hi_d         = hi_q;
    mid_d        = mid_q;
    idx_d        = idx_q;
    key_d        = key_q;
    res_d        = res_q;
    out_valid_d  = out_valid_q;
    out_res_d    = out_res_q;
    ram_we_o     = 1'b0;
    ram_raddr0_o = lo_q[Aw-1:0];
    ram_raddr1_o = hi_q[Aw-1:0];

    if (out_valid_q && rsp_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      SIdle: begin
        if (req_valid_i) begin
          unique case (req_operation_i)
            OpWrite: begin
              ram_we_o = (int'(req_entry_index_i) < TableDepth);
            end
            OpBinary: begin
              key_d        = key_in;
              lo_d         = '0;
              hi_d         = $signed({1'b0, used_u}) - Iw'(1);
              ram_raddr0_o = '0;
              ram_raddr1_o = hi_d[Aw-1:0];
              if (used_len == '0) begin
                res_d   = '0;
                state_d = SDone;
              end else begin
                state_d = SBound;
              end
            end
            OpSequential: begin
              key_d        = key_in;
              idx_d        = '0;
              ram_raddr0_o = '0;
              if (used_len == '0) begin
                res_d   = '0;
                state_d = SDone;
              end else begin
                state_d = SScan;
              end
            end
            default: ;
          endcase
        end
      end
      SBound: begin
        // rd0 holds entry lo, rd1 holds entry hi
        if (key_q < rd0 || key_q > rd1) begin
          res_d   = '0;
          state_d = SDone;
        end else begin
          mid_d        = mid_sum[Aw-1:0];
          ram_raddr0_o = mid_sum[Aw-1:0];
          state_d      = SMid;
        end
      end
      SMid: begin
        if (rd0 == key_q) begin
          res_d.found    = 1'b1;
          res_d.position = PosWidth'(mid_q);
          state_d        = SDone;
        end else begin
          if (key_q > rd0) begin
            lo_d = mid_ext + Iw'(1);
          end else begin
            hi_d = mid_ext - Iw'(1);
          end
          ram_raddr0_o = lo_d[Aw-1:0];
          ram_raddr1_o = hi_d[Aw-1:0];
          if (lo_d <= hi_d) begin
            state_d = SBound;
          end else begin
            res_d   = '0;
            state_d = SDone;
          end
        end
      end
      SScan: begin
        // next entry is fetched while the current one is compared
        ram_raddr0_o = idx_next[Aw-1:0];
        if (rd0 == key_q) begin
          res_d.found    = 1'b1;
          res_d.position = PosWidth'(idx_q);
          state_d        = SDone;
        end else if (idx_next == used_len) begin
          res_d   = '0;
          state_d = SDone;
        end else begin
          idx_d = idx_next;
        end
      end
      SDone: begin
        if (!out_valid_q || rsp_ready_i) begin
          out_valid_d = 1'b1;
          out_res_d   = res_q;
          state_d     = SIdle;
        end
      end
      default: begin
        state_d = SIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      length_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        length_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q      <= lo_d;
    hi_q      <= hi_d;
    mid_q     <= mid_d;
    idx_q     <= idx_d;
    key_q     <= key_d;
    res_q     <= res_d;
    out_res_q <= out_res_d;
  end

  assign rsp_valid_o  = out_valid_q;
  assign rsp_result_o = out_res_q;

endmodule

// ----- src/sorted_table_search_engine_core.sv -----
// top level of the sorted table search engine: sequencer and two table copies
// a write request is taken in the idle state; a binary search runs probe rounds of a bounds read
// then a midpoint read, ending when the key is found, falls outside the bounds or the range empties
// a linear search reads one entry a cycle and stops at the first match or at the end of the length
// one request at a time; the result register lets a new request in while a result waits
// reset clears the length register to zero and the result valid flag; table contents stay
`timescale 1ns / 1ps

module sorted_table_search_engine_core import sts_pkg::*; #(
  parameter int TableDepth = TableDepthDef,
  parameter int ValueWidth = ValueWidthDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  sts_req_if.sink                req_i,
  sts_rsp_if.source              rsp_o,
  input  logic                   cfg_we_i,
  input  logic [LengthWidth-1:0] cfg_wdata_i
);

  localparam int Aw = $clog2(TableDepth);

  logic                  ram_we;
  logic [Aw-1:0]         ram_waddr;
  logic [ValueWidth-1:0] ram_wdata;
  logic [Aw-1:0]         ram_raddr0, ram_raddr1;
  logic [ValueWidth-1:0] ram_rdata0, ram_rdata1;
  sts_result_t           result;

  sts_ctrl #(
    .TableDepth (TableDepth),
    .ValueWidth (ValueWidth)
  ) u_ctrl (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .req_valid_i       (req_i.valid),
    .req_ready_o       (req_i.ready),
    .req_operation_i   (req_i.operation),
    .req_entry_index_i (req_i.entry_index),
    .req_entry_value_i (req_i.entry_value),
    .req_search_key_i  (req_i.search_key),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .rsp_valid_o       (rsp_o.valid),
    .rsp_ready_i       (rsp_o.ready),
    .rsp_result_o      (result),
    .ram_we_o          (ram_we),
    .ram_waddr_o       (ram_waddr),
    .ram_wdata_o       (ram_wdata),
    .ram_raddr0_o      (ram_raddr0),
    .ram_raddr1_o      (ram_raddr1),
    .ram_rdata0_i      (ram_rdata0),
    .ram_rdata1_i      (ram_rdata1)
  );

  // two copies so both search bounds can be read in the same cycle
  sts_ram #(
    .Width (ValueWidth),
    .Depth (TableDepth)
  ) u_ram0 (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr0),
    .rdata_o (ram_rdata0)
  );

  sts_ram #(
    .Width (ValueWidth),
    .Depth (TableDepth)
  ) u_ram1 (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr1),
    .rdata_o (ram_rdata1)
  );

  assign rsp_o.found    = result.found;
  assign rsp_o.position = result.position;

endmodule

// ----- tb/sv/tb_sorted_table_search_engine_core.sv -----
// self-checking testbench for the sorted table search engine core
`timescale 1ns / 1ps

module tb_sorted_table_search_engine_core;
  import sts_pkg::*;

  localparam int ClkPeriod     = 12;
  localparam int TableDepth    = TableDepthDef;
  localparam int SettleCycles  = 40;
  localparam int LongHold      = 300;
  localparam int TargetItems   = 1700;
  localparam int PhaseSearches = 130;
  localparam int TimeoutCycles = 2_500_000;
  localparam int MinValue      = 32'sh8000_0000;
  localparam int MaxValue      = 32'sh7fff_ffff;
  localparam logic [OpWidth-1:0] OpUnused = 2'd3;

  typedef struct {
    logic [OpWidth-1:0]    op;
    logic [IndexWidth-1:0] idx;
    int                    val;
    int                    key;
  } lookup_req_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [LengthWidth-1:0] cfg_wdata_i;

  sts_req_if req_bus ();
  sts_rsp_if rsp_bus ();

  sorted_table_search_engine_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_bus),
    .rsp_o       (rsp_bus),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // predictor state, updated as requests are accepted
  int                     mirror_table [TableDepth];
  logic [LengthWidth-1:0] mirror_length;
  sts_result_t            search_outcomes [$];

  // generator view of the table, used to pick keys ahead of time
  int                     plan_table [TableDepth];
  int                     plan_length;
  lookup_req_t            request_backlog [$];
  int                     planned_items;

  int mismatches;
  bit source_calm;
  bit sink_calm;
  int holds_wanted;

  initial begin
    clk_i = 1'b0;
  end

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  function automatic int clip_length(int len);
    return (len > TableDepth) ? TableDepth : len;
  endfunction

  function automatic sts_result_t bisect_lookup(int key);
    int lo;
    int hi;
    int mid;
    sts_result_t res;
    res = '0;
    lo  = 0;
    hi  = clip_length(int'(mirror_length)) - 1;
    while (lo <= hi) begin
      if (key < mirror_table[lo] || key > mirror_table[hi]) return res;
      mid = (lo + hi) / 2;
      if (mirror_table[mid] == key) begin
        res.found    = 1'b1;
        res.position = mid[PosWidth-1:0];
        return res;
      end
      if (key > mirror_table[mid]) lo = mid + 1;
      else hi = mid - 1;
    end
    return res;
  endfunction

  function automatic sts_result_t scan_lookup(int key);
    sts_result_t res;
    res = '0;
    for (int i = 0; i < clip_length(int'(mirror_length)); i++) begin
      if (mirror_table[i] == key) begin
        res.found    = 1'b1;
        res.position = i[PosWidth-1:0];
        return res;
      end
    end
    return res;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // request driver
  lookup_req_t offered;
  int          send_gap;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_bus.valid       <= 1'b0;
      req_bus.operation   <= OpWrite;
      req_bus.entry_index <= '0;
      req_bus.entry_value <= '0;
      req_bus.search_key  <= '0;
      send_gap = 0;
    end else begin
      if (req_bus.valid && req_bus.ready) begin
        case (offered.op)
          OpWrite:      mirror_table[offered.idx] = offered.val;
          OpBinary:     search_outcomes.push_back(bisect_lookup(offered.key));
          OpSequential: search_outcomes.push_back(scan_lookup(offered.key));
          default:      ;
        endcase
      end
      if (!req_bus.valid || req_bus.ready) begin
        if (send_gap > 0) begin
          send_gap = send_gap - 1;
          req_bus.valid <= 1'b0;
        end else if (request_backlog.size() != 0) begin
          offered = request_backlog.pop_front();
          req_bus.operation   <= offered.op;
          req_bus.entry_index <= offered.idx;
          req_bus.entry_value <= offered.val;
          req_bus.search_key  <= offered.key;
          req_bus.valid       <= 1'b1;
          send_gap = source_calm ? 0 : pick_gap();
        end else begin
          req_bus.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and ready generator
  int          stall_left;
  int          holds_done;
  sts_result_t wanted;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_bus.ready <= 1'b0;
      stall_left = 0;
      holds_done = 0;
    end else begin
      if (rsp_bus.valid && rsp_bus.ready) begin
        if (search_outcomes.size() == 0) begin
          if (mismatches < 10)
            $display("unexpected result: found=%0d position=%0d",
                     rsp_bus.found, rsp_bus.position);
          mismatches++;
        end else begin
          wanted = search_outcomes.pop_front();
          if (rsp_bus.found !== wanted.found || rsp_bus.position !== wanted.position) begin
            if (mismatches < 10)
              $display("mismatch: expected found=%0d position=%0d, got found=%0d position=%0d",
                       wanted.found, wanted.position, rsp_bus.found, rsp_bus.position);
            mismatches++;
          end
        end
      end
      if (holds_done < holds_wanted) begin
        // long hold-off so the core backs up and stalls its request side
        holds_done++;
        stall_left = LongHold;
        rsp_bus.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        rsp_bus.ready <= 1'b0;
      end else if (!sink_calm && $urandom_range(0, 99) < 15) begin
        stall_left = pick_gap();
        rsp_bus.ready <= 1'b0;
      end else begin
        rsp_bus.ready <= 1'b1;
      end
    end
  end

  task automatic queue_write(int idx, int val);
    lookup_req_t it;
    it.op  = OpWrite;
    it.idx = idx[IndexWidth-1:0];
    it.val = val;
    it.key = int'($urandom());
    request_backlog.push_back(it);
    plan_table[idx] = val;
    planned_items++;
  endtask

  task automatic queue_search(logic [OpWidth-1:0] op, int key);
    lookup_req_t it;
    it.op  = op;
    it.idx = IndexWidth'($urandom_range(0, TableDepth - 1));
    it.val = int'($urandom());
    it.key = key;
    request_backlog.push_back(it);
    planned_items++;
  endtask

  task automatic queue_unused();
    lookup_req_t it;
    it.op  = OpUnused;
    it.idx = IndexWidth'($urandom_range(0, TableDepth - 1));
    it.val = int'($urandom());
    it.key = int'($urandom());
    request_backlog.push_back(it);
  endtask

  function automatic int pick_key();
    int n;
    int r;
    int i;
    n = clip_length(plan_length);
    r = $urandom_range(0, 99);
    i = (n > 0) ? $urandom_range(0, n - 1) : 0;
    if (n > 0 && r < 50) return plan_table[i];
    if (n > 0 && r < 65) return plan_table[i] + (($urandom_range(0, 1) != 0) ? 1 : -1);
    if (r < 75) begin
      case ($urandom_range(0, 3))
        0:       return MinValue;
        1:       return MaxValue;
        2:       return 0;
        default: return -1;
      endcase
    end
    if (r < 85) return $urandom_range(0, 40) - 20;
    return int'($urandom());
  endfunction

  // rewrite the whole table, normally sorted ascending
  task automatic load_table(bit sorted);
    int vals [TableDepth];
    int mode;
    int step;
    int tmp;
    int j;
    mode = $urandom_range(0, 3);
    step = $urandom_range(1, 1000);
    for (int i = 0; i < TableDepth; i++) begin
      case (mode)
        0:       vals[i] = int'($urandom());
        1:       vals[i] = $urandom_range(0, 40) - 20;  // many duplicates
        2:       vals[i] = i * step - 16 * step;
        default: vals[i] = int'($urandom()) >>> $urandom_range(0, 31);
      endcase
    end
    if (mode == 3) begin
      vals[0]              = MinValue;
      vals[TableDepth - 1] = MaxValue;
    end
    if (sorted) begin
      for (int i = 1; i < TableDepth; i++) begin
        tmp = vals[i];
        j   = i - 1;
        while (j >= 0 && vals[j] > tmp) begin
          vals[j + 1] = vals[j];
          j--;
        end
        vals[j + 1] = tmp;
      end
    end
    for (int i = 0; i < TableDepth; i++) queue_write(i, vals[i]);
  endtask

  task automatic wait_idle();
    do @(negedge clk_i);
    while (request_backlog.size() != 0 || req_bus.valid || search_outcomes.size() != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // drain, write the length register, and resume at a falling edge
  task automatic set_length(int len);
    wait_idle();
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= len[LengthWidth-1:0];
    @(posedge clk_i);
    cfg_we_i      <= 1'b0;
    mirror_length = len[LengthWidth-1:0];
    plan_length   = len;
    @(negedge clk_i);
  endtask

  initial begin
    int lengths [10] = '{32, 1, 0, 63, 2, 33, 31, 7, 16, 5};
    int phase;
    int len;
    int r;
    req_bus.valid       = 1'b0;
    req_bus.operation   = OpWrite;
    req_bus.entry_index = '0;
    req_bus.entry_value = '0;
    req_bus.search_key  = '0;
    rsp_bus.ready       = 1'b0;
    cfg_we_i            = 1'b0;
    cfg_wdata_i         = '0;
    mismatches          = 0;
    planned_items       = 0;
    source_calm         = 1'b0;
    sink_calm           = 1'b0;
    holds_wanted        = 0;
    mirror_length       = '0;
    plan_length         = 0;
    rst_ni              = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // load a sorted table with both extremes at the ends, length still zero
    for (int i = 0; i < TableDepth; i++) begin
      queue_write(i, (i == 0) ? MinValue :
                     (i == TableDepth - 1) ? MaxValue : (i - 16) * 1000);
    end
    queue_search(OpBinary, 0);
    queue_search(OpSequential, 0);
    queue_unused();

    set_length(32);
    queue_search(OpBinary, MinValue);
    queue_search(OpBinary, MaxValue);
    queue_search(OpBinary, 0);
    queue_search(OpBinary, 500);           // falls between entries, caught by the bounds check
    queue_search(OpBinary, MinValue + 1);
    queue_search(OpSequential, MaxValue);  // scans the whole table
    queue_search(OpSequential, 7);
    queue_search(OpSequential, MinValue);
    queue_unused();

    set_length(63);                        // clipped to the table depth
    queue_search(OpBinary, MaxValue);
    queue_search(OpSequential, MaxValue);
    queue_search(OpBinary, -1000);

    set_length(1);
    queue_search(OpBinary, MinValue);
    queue_search(OpBinary, MaxValue);
    queue_search(OpSequential, MinValue);

    phase = 0;
    while (planned_items < TargetItems) begin
      len = (phase < 10) ? lengths[phase] : $urandom_range(0, 63);
      set_length(len);
      source_calm = (phase % 4 == 2);
      sink_calm   = (phase % 4 == 3);
      if (phase == 1 || phase == 6) holds_wanted++;
      load_table(phase != 4);
      repeat (PhaseSearches) begin
        r = $urandom_range(0, 99);
        if (r < 5) queue_write($urandom_range(0, TableDepth - 1), int'($urandom()));
        else if (r < 8) queue_unused();
        else queue_search((r < 55) ? OpBinary : OpSequential, pick_key());
      end
      phase++;
    end

    wait_idle();
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #(TimeoutCycles * ClkPeriod);
    $display("status: fail");
    $finish;
  end

endmodule
